/* rtl/scs_pkg.sv */
// shared types and constants for the strided cumulative scan
package scs_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int ELEM_W     = 32;
  localparam int STRIDE_W   = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OP_MODE      = 2'd0,
    CFG_SCAN_LENGTH  = 2'd1,
    CFG_INNER_STRIDE = 2'd2,
    CFG_UNUSED       = 2'd3
  } scs_cfg_idx_t;

  // per-item control carried into the accumulate stage
  typedef struct packed {
    logic first;  // first position of its line, start from identity
    logic fwd;    // previous item hit the same line, take bypass value
    logic mul;    // product mode
  } scs_ctl_t;

endpackage

/* rtl/strided_cumulative_scan.sv */
// strided cumulative scan: an accepted input is registered in the accumulate stage, then in the output register
// throughput one item per cycle while out_ready does not stall the output, bound by one ram read and write per item
// read issued at accept, modify and write back in the next stage
// back-to-back items on the same line (stride 1) take the bypass register
// reset: op_mode 0, length and stride 1, position counters zero, pipeline empty
// accumulator ram is not cleared: each line starts from the identity at position 0
module strided_cumulative_scan #(
  parameter int DATA_WIDTH = 32,
  parameter int MAX_STRIDE = 1024,
  parameter int MAX_LENGTH = 65536
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [scs_pkg::ELEM_W-1:0] element_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [scs_pkg::ELEM_W-1:0] running_value,
  output logic                             line_end,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [scs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import scs_pkg::*;

  localparam int LINE_W = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1;
  localparam int POS_W  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

  // configuration, lengths held as last index
  logic              op_mode;
  logic [POS_W-1:0]  len_last;
  logic [LINE_W-1:0] stride_last;

  // position counters
  logic [LINE_W-1:0] inner_pos;
  logic [LINE_W-1:0] inner_pos_next;
  logic [POS_W-1:0]  scan_pos;
  logic [POS_W-1:0]  scan_pos_next;

  // accumulate stage
  logic                  s1_valid;
  logic [LINE_W-1:0]     s1_line;
  logic [DATA_WIDTH-1:0] s1_x;
  logic                  s1_last;
  scs_ctl_t              s1_ctl;
  logic                  s1_adv;
  logic [DATA_WIDTH-1:0] acc_new;

  logic     in_acc;
  logic     cfg_acc;
  logic     is_last;
  scs_ctl_t ctl_in;

  logic [31:0] len_n;
  logic [31:0] stride_n;

  assign s1_adv    = s1_valid && (!out_valid || out_ready);
  // nothing is taken while reset is held
  assign in_ready  = !rst && (!s1_valid || s1_adv);
  assign in_acc    = in_valid && in_ready;
  // writes land only with the pipeline drained
  assign cfg_ready = !rst && !s1_valid && !out_valid;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign is_last   = (scan_pos == len_last);

  // zero acts as one, oversize saturates
  always_comb begin
    len_n = 32'(cfg_data);
    if (len_n == 32'd0) begin
      len_n = 32'd1;
    end else if (len_n > 32'(MAX_LENGTH)) begin
      len_n = 32'(MAX_LENGTH);
    end
    stride_n = 32'(cfg_data[STRIDE_W-1:0]);
    if (stride_n == 32'd0) begin
      stride_n = 32'd1;
    end else if (stride_n > 32'(MAX_STRIDE)) begin
      stride_n = 32'(MAX_STRIDE);
    end
  end

  // walk the lines of a stride group, then step along the scanned dimension
  always_comb begin
    if (inner_pos == stride_last) begin
      inner_pos_next = '0;
      scan_pos_next  = is_last ? '0 : scan_pos + POS_W'(1);
    end else begin
      inner_pos_next = inner_pos + LINE_W'(1);
      scan_pos_next  = scan_pos;
    end
  end

  always_comb begin
    ctl_in.first = (scan_pos == '0);
    ctl_in.mul   = op_mode;
    // ram read would race the write of the item leaving this edge
    ctl_in.fwd   = s1_adv && (s1_line == inner_pos);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode     <= 1'b0;
      len_last    <= '0;
      stride_last <= '0;
      inner_pos   <= '0;
      scan_pos    <= '0;
    end else if (cfg_acc) begin
      unique case (scs_cfg_idx_t'(cfg_index))
        CFG_OP_MODE: begin
          op_mode <= cfg_data[0];
        end
        CFG_SCAN_LENGTH: begin
          len_last  <= POS_W'(len_n - 32'd1);
          inner_pos <= '0;
          scan_pos  <= '0;
        end
        CFG_INNER_STRIDE: begin
          stride_last <= LINE_W'(stride_n - 32'd1);
          inner_pos   <= '0;
          scan_pos    <= '0;
        end
        default: begin
        end
      endcase
    end else if (in_acc) begin
      inner_pos <= inner_pos_next;
      scan_pos  <= scan_pos_next;
    end
  end

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_acc;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_line <= inner_pos;
      s1_x    <= DATA_WIDTH'(element_value);
      s1_last <= is_last;
      s1_ctl  <= ctl_in;
    end
    if (s1_adv) begin
      running_value <= ELEM_W'(acc_new);
      line_end      <= s1_last;
    end
  end

  scs_accum #(
    .DATA_WIDTH (DATA_WIDTH),
    .DEPTH      (MAX_STRIDE),
    .LINE_W     (LINE_W)
  ) u_accum (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_line (inner_pos),
    .wr_en   (s1_adv),
    .wr_line (s1_line),
    .ctl     (s1_ctl),
    .operand (s1_x),
    .acc_new (acc_new)
  );

endmodule

/* rtl/scs_accum.sv */
// accumulator ram with read-modify-write datapath and same-line bypass
module scs_accum #(
  parameter int DATA_WIDTH = 32,
  parameter int DEPTH      = 1024,
  parameter int LINE_W     = 10
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [LINE_W-1:0]     rd_line,
  input  logic                  wr_en,
  input  logic [LINE_W-1:0]     wr_line,
  input  scs_pkg::scs_ctl_t     ctl,
  input  logic [DATA_WIDTH-1:0] operand,
  output logic [DATA_WIDTH-1:0] acc_new
);
  import scs_pkg::*;

  logic [DATA_WIDTH-1:0]   mem [DEPTH];
  logic [DATA_WIDTH-1:0]   rd_data;
  logic [DATA_WIDTH-1:0]   last_acc;
  logic [DATA_WIDTH-1:0]   acc_old;
  logic [DATA_WIDTH-1:0]   prod;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_line];
    end
    if (wr_en) begin
      mem[wr_line] <= acc_new;
      last_acc     <= acc_new;
    end
  end

  always_comb begin
    priority if (ctl.first) begin
      acc_old = ctl.mul ? DATA_WIDTH'(1) : '0;
    end else if (ctl.fwd) begin
      acc_old = last_acc;
    end else begin
      acc_old = rd_data;
    end
    // only the low half of the product is kept, so the multiply wraps
    prod = acc_old * operand;
    acc_new = ctl.mul ? prod : acc_old + operand;
  end

endmodule

/* rtl/scs_checker.sv */
// port-level checker for the strided cumulative scan and its bind
module scs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] running_value,
  input logic        line_end,
  input logic        cfg_ready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(running_value) && $stable(line_end))
    else $error("result changed while stalled");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // configuration only taken with no result pending
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !out_valid)
    else $error("config ready with result pending");

  // an item entering an empty pipe passes the accumulate stage before it appears at the output
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cfg_ready |=> !out_valid ##1 out_valid)
    else $error("latency from empty pipe is not two cycles");

endmodule

bind strided_cumulative_scan scs_checker u_scs_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .running_value (running_value),
  .line_end      (line_end),
  .cfg_ready     (cfg_ready)
);
